/* rtl/serial_port_shift_engine_defines.svh */
// assertion macros shared by the serial port shift engine rtl
`ifndef SERIAL_PORT_SHIFT_ENGINE_DEFINES_SVH
`define SERIAL_PORT_SHIFT_ENGINE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define SPS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequence holds in the same cycle as the antecedent
`define SPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sps_pkg.sv */
// types and constants of the serial port shift engine
`default_nettype none

package sps_pkg;

	localparam int unsigned FRAME_BITS = 10;
	localparam int unsigned CNT_W      = $clog2(FRAME_BITS + 1);
	localparam int unsigned ADDR_W     = 3;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned CTL_W      = 8;

	// register indexes
	localparam logic [ADDR_W-3:0] REG_CTRL = '0;

	// control byte bit positions
	localparam int unsigned CTL_TWOTONE = 3;
	localparam int unsigned CTL_ASYNC   = 4;
	localparam int unsigned CTL_BREAK   = 7;

	// clock mode codes and ranges
	localparam logic [2:0] MODE_EXT_RX_A = 3'd0;
	localparam logic [2:0] MODE_EXT_RX_B = 3'd4;
	localparam logic [2:0] MODE_EXT_TX_HI = 3'd1;
	localparam logic [2:0] MODE_T4_TX_LO = 3'd2;
	localparam logic [2:0] MODE_T4_TX_HI = 3'd5;
	localparam logic [2:0] MODE_T2_TX_LO = 3'd6;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_CONTROL = 2'd2,
		OP_RESET   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic       timer1_edge;
		logic       timer2_edge;
		logic       timer4_edge;
		logic       line_data;
		logic       line_clock;
		logic       input_irq_pending;
	} sps_in_t;

	typedef struct packed {
		logic [7:0] received_byte;
		logic       serial_out;
		logic       busy_res;
		logic       frame_error_set;
		logic       overrun_set;
		logic       rx_irq_request;
		logic       tx_irq_request;
		logic       complete_irq_request;
		logic       complete_irq_ack;
		logic       timer34_reset;
		logic [1:0] twotone_resync;
		logic       holds_timer34;
	} sps_out_t;

	// one item handed to the engine for processing
	typedef struct packed {
		logic    go;
		sps_in_t item;
	} sps_step_t;

endpackage

`default_nettype wire

/* rtl/sps_apb.sv */
// apb register port holding the serial control byte
`default_nettype none

module sps_apb (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sps_pkg::DATA_W-1:0] pwdata,
	output logic      [sps_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output logic      [sps_pkg::CTL_W-1:0]  ctl
);

	logic [sps_pkg::CTL_W-1:0] ctl_q;
	logic                      hit;

	assign hit    = (paddr[sps_pkg::ADDR_W-1:2] == sps_pkg::REG_CTRL);
	assign pready = 1'b1;
	assign ctl    = ctl_q;
	assign prdata = hit ? sps_pkg::DATA_W'(ctl_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (psel && penable && pwrite && hit) begin
			ctl_q <= pwdata[sps_pkg::CTL_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/sps_engine.sv */
// serial port state and the combinational step logic for one item
`default_nettype none
`include "serial_port_shift_engine_defines.svh"

module sps_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [sps_pkg::CTL_W-1:0] ctl,
	input  wire sps_pkg::sps_step_t        step,
	output sps_pkg::sps_out_t              res
);

	localparam logic [sps_pkg::CNT_W-1:0] LAST_RX = sps_pkg::CNT_W'(sps_pkg::FRAME_BITS - 1);
	localparam logic [sps_pkg::CNT_W-1:0] LAST_TX = sps_pkg::CNT_W'(sps_pkg::FRAME_BITS);
	localparam logic [sps_pkg::CNT_W-1:0] ONE     = sps_pkg::CNT_W'(1);

	logic [sps_pkg::FRAME_BITS-1:0] rx_shift_q, rx_shift_d, tx_shift_q, tx_shift_d;
	logic [sps_pkg::CNT_W-1:0]      rx_count_q, rx_count_d, tx_count_q, tx_count_d;
	logic [7:0]                     rx_byte_q, rx_byte_d, tx_hold_q, tx_hold_d;
	logic tx_full_q, tx_full_d, rx_phase_q, rx_phase_d, tx_phase_q, tx_phase_d;
	logic tx_line_q, tx_line_d, tone_q, tone_d, async_q, async_d;
	logic last_data_q, last_data_d, last_clock_q, last_clock_d, rx_busy_q, rx_busy_d;

	logic       ferr, ovr, rxirq, txirq, creq, cack, t34;
	logic [1:0] tone_acc;
	logic       rx_edge, tx_edge, tx_tmr, load;
	logic       in_fall, clk_fall, clk_rise, async_in;
	logic [2:0] mode;
	sps_pkg::sps_in_t it;

	assign it       = step.item;
	assign mode     = ctl[6:4];
	assign async_in = ctl[sps_pkg::CTL_ASYNC];
	assign in_fall  = last_data_q & ~it.line_data;
	assign clk_fall = last_clock_q & ~it.line_clock;
	assign clk_rise = ~last_clock_q & it.line_clock;

	always_comb begin
		rx_shift_d   = rx_shift_q;
		rx_count_d   = rx_count_q;
		rx_byte_d    = rx_byte_q;
		tx_hold_d    = tx_hold_q;
		tx_full_d    = tx_full_q;
		tx_shift_d   = tx_shift_q;
		tx_count_d   = tx_count_q;
		rx_phase_d   = rx_phase_q;
		tx_phase_d   = tx_phase_q;
		tx_line_d    = tx_line_q;
		tone_d       = tone_q;
		async_d      = async_q;
		last_data_d  = last_data_q;
		last_clock_d = last_clock_q;
		rx_busy_d    = rx_busy_q;
		ferr = 1'b0; ovr = 1'b0; rxirq = 1'b0; txirq = 1'b0;
		creq = 1'b0; cack = 1'b0; t34 = 1'b0;
		tone_acc = 2'b00;
		rx_edge = 1'b0; tx_edge = 1'b0; tx_tmr = 1'b0; load = 1'b0;
		if (step.go) begin
			unique case (it.operation)
				sps_pkg::OP_TICK: begin
					last_data_d  = it.line_data;
					last_clock_d = it.line_clock;
					// receive path: start-edge resync in async mode
					if (async_in && rx_count_q == '0 && in_fall) begin
						async_d    = 1'b1;
						rx_phase_d = 1'b1;
						t34        = 1'b1;
					end
					if (mode == sps_pkg::MODE_EXT_RX_A || mode == sps_pkg::MODE_EXT_RX_B) begin
						rx_edge = clk_fall;
					end else if (it.timer4_edge && (!async_in || async_d)) begin
						rx_phase_d = ~rx_phase_d;
						rx_edge    = ~rx_phase_d;
					end
					if (rx_edge) begin
						if (rx_count_q == '0) begin
							if (!it.line_data) begin
								rx_shift_d = '0;
								rx_count_d = ONE;
								rx_busy_d  = 1'b1;
							end
						end else begin
							rx_shift_d[rx_count_q] = it.line_data;
							if (rx_count_q == LAST_RX) begin
								// stop bit sampled: frame done
								rx_byte_d  = rx_shift_d[8:1];
								ferr       = ~it.line_data;
								rx_shift_d = '0;
								rx_count_d = '0;
								async_d    = 1'b0;
								rx_busy_d  = 1'b0;
								rxirq      = 1'b1;
								ovr        = it.input_irq_pending;
								if (async_in) begin
									t34 = 1'b1;
								end
							end else begin
								rx_count_d = rx_count_q + ONE;
							end
						end
						if (async_in && rx_count_d == '0) begin
							async_d = 1'b0;
							t34     = 1'b1;
						end
					end
					// transmit path
					if (mode >= sps_pkg::MODE_T4_TX_LO && mode <= sps_pkg::MODE_T4_TX_HI) begin
						tx_tmr = it.timer4_edge;
					end else if (mode >= sps_pkg::MODE_T2_TX_LO) begin
						tx_tmr = it.timer2_edge;
					end
					if (mode <= sps_pkg::MODE_EXT_TX_HI) begin
						tx_edge = clk_rise;
						if (clk_fall) begin
							tx_phase_d = 1'b0;
						end
						if (clk_rise) begin
							tx_phase_d = 1'b1;
						end
					end
					if (tx_tmr) begin
						tx_phase_d = ~tx_phase_d;
						tx_edge    = tx_phase_d;
					end
					if (tx_edge) begin
						if (tx_count_q == '0) begin
							load = tx_full_q;
						end else if (tx_count_q < LAST_TX) begin
							tx_line_d  = tx_shift_q[tx_count_q];
							tx_count_d = tx_count_q + ONE;
						end else begin
							tx_shift_d = '0;
							tx_count_d = '0;
							load       = tx_full_q;
							creq       = ~tx_full_q;
						end
						if (load) begin
							tx_shift_d = {1'b1, tx_hold_q, 1'b0};
							tx_count_d = ONE;
							tx_hold_d  = '0;
							tx_full_d  = 1'b0;
							tx_line_d  = 1'b0;
							cack       = 1'b1;
							txirq      = 1'b1;
						end
					end
					// two-tone generator
					if (ctl[sps_pkg::CTL_TWOTONE]) begin
						tone_acc = {it.timer2_edge,
							it.timer1_edge & tx_line_d & ~ctl[sps_pkg::CTL_BREAK]};
						if (tone_acc != 2'b00) begin
							tone_d = ~tone_q;
						end
					end
				end
				sps_pkg::OP_WRITE: begin
					if (ctl[1:0] != 2'b00) begin
						tx_hold_d = it.data_byte;
						tx_full_d = 1'b1;
					end
				end
				sps_pkg::OP_CONTROL: begin
					if (mode == sps_pkg::MODE_EXT_RX_A) begin
						rx_phase_d   = 1'b0;
						tx_phase_d   = 1'b0;
						last_clock_d = it.line_clock;
					end
					if (!ctl[sps_pkg::CTL_TWOTONE]) begin
						tone_d = 1'b0;
					end
					if (async_in && rx_count_q == '0) begin
						async_d = 1'b0;
						t34     = 1'b1;
					end else begin
						async_d = async_in;
					end
				end
				sps_pkg::OP_RESET: begin
					rx_shift_d = '0;
					rx_count_d = '0;
					tx_hold_d  = '0;
					tx_full_d  = 1'b0;
					tx_shift_d = '0;
					tx_count_d = '0;
					rx_phase_d = 1'b0;
					tx_phase_d = 1'b0;
					async_d    = 1'b0;
					rx_busy_d  = 1'b0;
					creq       = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.received_byte        = rx_byte_d;
		res.serial_out           = ctl[sps_pkg::CTL_TWOTONE] ? tone_d :
			(ctl[sps_pkg::CTL_BREAK] ? 1'b0 : tx_line_d);
		res.busy_res             = rx_busy_d;
		res.frame_error_set      = ferr;
		res.overrun_set          = ovr;
		res.rx_irq_request       = rxirq;
		res.tx_irq_request       = txirq;
		res.complete_irq_request = creq;
		res.complete_irq_ack     = cack;
		res.timer34_reset        = t34;
		res.twotone_resync       = tone_acc;
		res.holds_timer34        = async_in & ~async_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_shift_q   <= '0;
			rx_count_q   <= '0;
			rx_byte_q    <= '1;
			tx_hold_q    <= '0;
			tx_full_q    <= 1'b0;
			tx_shift_q   <= '0;
			tx_count_q   <= '0;
			rx_phase_q   <= 1'b0;
			tx_phase_q   <= 1'b0;
			tx_line_q    <= 1'b1;
			tone_q       <= 1'b0;
			async_q      <= 1'b0;
			last_data_q  <= 1'b1;
			last_clock_q <= 1'b1;
			rx_busy_q    <= 1'b0;
		end else if (step.go) begin
			rx_shift_q   <= rx_shift_d;
			rx_count_q   <= rx_count_d;
			rx_byte_q    <= rx_byte_d;
			tx_hold_q    <= tx_hold_d;
			tx_full_q    <= tx_full_d;
			tx_shift_q   <= tx_shift_d;
			tx_count_q   <= tx_count_d;
			rx_phase_q   <= rx_phase_d;
			tx_phase_q   <= tx_phase_d;
			tx_line_q    <= tx_line_d;
			tone_q       <= tone_d;
			async_q      <= async_d;
			last_data_q  <= last_data_d;
			last_clock_q <= last_clock_d;
			rx_busy_q    <= rx_busy_d;
		end
	end

	`SPS_ASSERT_ALWAYS(a_rx_count_range, rx_count_q <= LAST_RX, "receive bit count out of range")
	`SPS_ASSERT_ALWAYS(a_tx_count_range, tx_count_q <= LAST_TX, "transmit bit count out of range")
	`SPS_ASSERT_ALWAYS(a_busy_match, rx_busy_q == (rx_count_q != '0), "busy flag disagrees with count")

endmodule

`default_nettype wire

/* rtl/serial_port_shift_engine.sv */
// serial port shift engine top level: item pipeline and register port
//
// one input channel (in_valid, in_stall, in_data) carries items: a tick with
// timer edges and line levels, a transmit byte write, a control change or a
// serial reset. one output channel (out_valid, out_stall, out_data) returns
// exactly one result item per input item, in order.
// an accepted item is held in the input register until it can advance; the
// step logic then updates the port state and the result is loaded into the
// output register, which drives out_valid.
// throughput is one item per cycle while results are taken; the state
// update is a single pass of logic between the input and result registers.
// when the receiver stalls, a held result keeps the input register full and
// in_stall is raised until the result is taken; nothing is dropped.
// the control byte is written through the apb port at byte address 0 and
// should only change while no item is in flight.
// asynchronous reset clears the pipeline and returns the port to its idle
// state: line high, received byte all ones, no interrupt requested.
`default_nettype none
`include "serial_port_shift_engine_defines.svh"

module serial_port_shift_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire sps_pkg::sps_in_t           in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output sps_pkg::sps_out_t               out_data,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sps_pkg::DATA_W-1:0] pwdata,
	output logic      [sps_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);

	logic                      vld_s1;
	sps_pkg::sps_in_t          item_s1;
	logic                      out_vld_q;
	sps_pkg::sps_out_t         out_q;
	logic                      advance;
	logic                      accept;
	logic [sps_pkg::CTL_W-1:0] ctl;
	sps_pkg::sps_step_t        step;
	sps_pkg::sps_out_t         res;

	assign advance   = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall  = vld_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign step.go   = advance;
	assign step.item = item_s1;

	sps_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ctl     (ctl)
	);

	sps_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.step   (step),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	`SPS_ASSERT_IMPLY(a_stall_needs_item, in_stall, vld_s1, "input stalled with empty stage")
	`SPS_ASSERT_NEXT(a_advance_gives_result, advance, out_vld_q, "processed item gave no result")
	`SPS_ASSERT_NEXT(a_taken_result_clears, out_vld_q && !out_stall && !vld_s1, !out_vld_q, "taken result shown again")

endmodule

`default_nettype wire
